[sv/free_hole_segment_allocator_macros.svh]
// Assertion helpers for the hole allocator.
`ifndef FREE_HOLE_SEGMENT_ALLOCATOR_MACROS_SVH
`define FREE_HOLE_SEGMENT_ALLOCATOR_MACROS_SVH
// implication checked every clock, quiet in reset
`define FHSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define FHSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[sv/fhsa_pkg.sv]
package fhsa_pkg;
	localparam int unsigned ADDR_LIMIT = 65536;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_FREE  = 3'd1,
		CMD_TOTAL = 3'd2,
		CMD_CONTIG = 3'd3,
		CMD_INIT  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_POLICY   = 2'd0,
		REG_MEM_SIZE = 2'd1,
		REG_RESERVED = 2'd2
	} reg_idx_t;

	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_DECIDE,
		S_WRITE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SUM_RD,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] seg_base;
		logic [16:0] seg_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] alloc_base;
		logic        answer;
		logic [16:0] free_total;
	} rsp_t;
endpackage

[sv/fhsa_if.sv]
interface fhsa_req_if;
	import fhsa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fhsa_rsp_if;
	import fhsa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/free_hole_segment_allocator.sv]
// Hole allocator: one command in flight, walked through a single table port.
// Flow: init, a total check or an unused command go straight to the sum walk over the holes in
//   use; a contiguous check, an alloc or a free first scan the holes, and an alloc or free that
//   removes an entry or a free that opens a new slot shift entries before the sum walk.
// One command at a time: a new one is taken only in idle; a waiting result beat holds the finish.
// Reset: hole count, config (policy 0, size 4096, reserved 128) and control clear at once;
//   table contents are not cleared, only entries below the count are read.
module free_hole_segment_allocator #(
	parameter int unsigned MAX_HOLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	fhsa_req_if.sink    req,
	fhsa_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import fhsa_pkg::*;

	localparam int unsigned AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int unsigned CW = $clog2(MAX_HOLES + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_HOLES);

	// configuration
	logic [1:0]  policy_q;
	logic [16:0] memsize_q, reserved_q;

	// control
	state_t      state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;     // scan / shift pointer
	req_t        req_q, req_d;
	// scan results
	logic        found_q, found_d;
	logic [AW-1:0] pick_q, pick_d;
	logic [16:0] pick_len_q, pick_len_d;
	logic [15:0] pick_start_q, pick_start_d;
	logic        bad_q, bad_d;       // free overlaps
	logic [CW-1:0] pos_q, pos_d;     // free insertion point
	logic [15:0] lo_start_q, lo_start_d; // hole below insertion point
	logic [16:0] lo_len_q, lo_len_d;
	logic [15:0] hi_start_q, hi_start_d; // hole at insertion point
	logic [16:0] hi_len_q, hi_len_d;
	logic        ans_q, ans_d;
	logic [1:0]  stat_q, stat_d;
	logic [15:0] abase_q, abase_d;
	logic [16:0] sum_q, sum_d;
	logic        remove_q, remove_d; // shift down over the removed entry (else up)
	// final write after shifting
	logic [AW-1:0] fw_addr_q, fw_addr_d;
	logic [15:0] fw_start_q, fw_start_d;
	logic [16:0] fw_len_q, fw_len_d;
	logic        fw_en_q, fw_en_d;
	// output register
	logic        ovalid_q;
	rsp_t        odata_q;
	logic        load_out;           // result moves into the output register

	// table port
	logic          t_we;
	logic [AW-1:0] t_waddr, t_raddr;
	logic [15:0]   t_wstart, t_rstart;
	logic [16:0]   t_wlen, t_rlen;

	fhsa_table #(.DEPTH(MAX_HOLES), .AW(AW)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wstart(t_wstart), .wlen(t_wlen),
		.raddr(t_raddr), .rstart(t_rstart), .rlen(t_rlen)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.data  = odata_q;
	assign load_out  = (state_q == S_DONE) && (!ovalid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= '0;
			memsize_q  <= 17'd4096;
			reserved_q <= 17'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY:   policy_q   <= cfg_data[1:0];
				REG_MEM_SIZE: memsize_q  <= cfg_data;
				REG_RESERVED: reserved_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared compare/add datapath signals
	logic [16:0] hole_end;     // start + length of the entry being read
	logic [17:0] req_end;      // base + size of a free
	logic [16:0] top;

	always_comb begin
		hole_end = 17'(t_rstart) + t_rlen;
		req_end  = 18'(req_q.seg_base) + 18'(req_q.seg_size);
		top      = (memsize_q > 17'(ADDR_LIMIT)) ? 17'(ADDR_LIMIT) : memsize_q;
	end

	always_comb begin
		logic low, high;
		logic [17:0] merged;
		state_d = state_q; count_d = count_q; idx_d = idx_q; req_d = req_q;
		found_d = found_q; pick_d = pick_q; pick_len_d = pick_len_q;
		pick_start_d = pick_start_q; bad_d = bad_q; pos_d = pos_q;
		lo_start_d = lo_start_q; lo_len_d = lo_len_q;
		hi_start_d = hi_start_q; hi_len_d = hi_len_q;
		ans_d = ans_q; stat_d = stat_q; abase_d = abase_q; sum_d = sum_q;
		remove_d = remove_q;
		fw_addr_d = fw_addr_q; fw_start_d = fw_start_q; fw_len_d = fw_len_q;
		fw_en_d = fw_en_q;
		t_we = 1'b0; t_waddr = '0; t_wstart = '0; t_wlen = '0;
		t_raddr = idx_q[AW-1:0];
		low = 1'b0; high = 1'b0; merged = '0;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					req_d = req.data;
					idx_d = '0; found_d = 1'b0; bad_d = 1'b0; pos_d = '0;
					ans_d = 1'b0; stat_d = ST_OK; abase_d = '0; sum_d = '0;
					fw_en_d = 1'b0; remove_d = 1'b0;
					if (req.data.cmd == CMD_INIT) begin
						if (reserved_q < top) begin
							t_we = 1'b1; t_waddr = '0;
							t_wstart = reserved_q[15:0];
							t_wlen = top - reserved_q;
							count_d = CW'(1);
						end else begin
							count_d = '0;
						end
						state_d = S_SUM_RD;
					end else if (req.data.cmd == CMD_ALLOC || req.data.cmd == CMD_FREE
							|| req.data.cmd == CMD_CONTIG) begin
						state_d = S_SCAN_RD;
					end else begin
						state_d = S_SUM_RD;
					end
				end
			end
			S_SCAN_RD: begin
				// address idx presented; data valid next cycle
				if (idx_q >= count_q) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				case (req_q.cmd)
					CMD_ALLOC: begin
						if (t_rlen >= req_q.seg_size) begin
							if (!found_q
								|| (policy_q == POL_BEST && t_rlen < pick_len_q)
								|| (policy_q == POL_WORST && t_rlen > pick_len_q)) begin
								found_d = 1'b1; pick_d = idx_q[AW-1:0];
								pick_len_d = t_rlen; pick_start_d = t_rstart;
							end
						end
					end
					CMD_FREE: begin
						if (18'(t_rstart) < req_end
							&& 17'(req_q.seg_base) < hole_end) begin
							bad_d = 1'b1;
						end
						if (t_rstart < req_q.seg_base) begin
							pos_d = idx_q + CW'(1);
							lo_start_d = t_rstart; lo_len_d = t_rlen;
						end else if (pos_q == idx_q) begin
							hi_start_d = t_rstart; hi_len_d = t_rlen;
						end
					end
					default: begin
						if (t_rlen >= req_q.seg_size) ans_d = 1'b1;
					end
				endcase
				idx_d = idx_q + CW'(1);
				// first fit stops at the first hit
				if (req_q.cmd == CMD_ALLOC && policy_q != POL_BEST && policy_q != POL_WORST
					&& t_rlen >= req_q.seg_size) begin
					state_d = S_DECIDE;
				end else begin
					t_raddr = idx_d[AW-1:0];
					state_d = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				state_d = S_SUM_RD;
				if (req_q.cmd == CMD_ALLOC) begin
					if (!found_q) begin
						stat_d = ST_FAIL;
					end else begin
						abase_d = pick_start_q;
						if (pick_len_q == req_q.seg_size) begin
							remove_d = 1'b1;
							idx_d = CW'(pick_q);
							count_d = count_q - CW'(1);
							state_d = S_SHIFT_RD;
						end else begin
							t_we = 1'b1; t_waddr = pick_q;
							t_wstart = pick_start_q + req_q.seg_size[15:0];
							t_wlen = pick_len_q - req_q.seg_size;
						end
					end
				end else if (req_q.cmd == CMD_FREE) begin
					low  = (pos_q != '0) && (17'(lo_start_q) + lo_len_q
						== 17'(req_q.seg_base));
					high = (pos_q < count_q) && (req_end == 18'(hi_start_q));
					if (req_q.seg_size == '0) begin
						stat_d = ST_OK;
					end else if (req_end > 18'(ADDR_LIMIT) || bad_q) begin
						stat_d = ST_FAIL;
					end else if (low && high) begin
						merged = 18'(lo_len_q) + 18'(req_q.seg_size) + 18'(hi_len_q);
						t_we = 1'b1; t_waddr = AW'(pos_q - CW'(1));
						t_wstart = lo_start_q; t_wlen = merged[16:0];
						remove_d = 1'b1; idx_d = pos_q;
						count_d = count_q - CW'(1);
						state_d = S_SHIFT_RD;
					end else if (low) begin
						t_we = 1'b1; t_waddr = AW'(pos_q - CW'(1));
						t_wstart = lo_start_q; t_wlen = lo_len_q + req_q.seg_size;
					end else if (high) begin
						t_we = 1'b1; t_waddr = AW'(pos_q);
						t_wstart = req_q.seg_base; t_wlen = hi_len_q + req_q.seg_size;
					end else if (count_q >= FULL) begin
						stat_d = ST_FULL;
					end else begin
						// open a slot at pos: walk from the top downwards
						remove_d = 1'b0; idx_d = count_q;
						fw_en_d = 1'b1; fw_addr_d = AW'(pos_q);
						fw_start_d = req_q.seg_base; fw_len_d = req_q.seg_size;
						count_d = count_q + CW'(1);
						state_d = S_SHIFT_RD;
					end
				end
			end
			S_SHIFT_RD: begin
				// remove: copy idx+1 to idx while idx < count; insert: copy idx-1 to idx
				if (remove_q) begin
					if (idx_q >= count_q) begin
						state_d = S_SUM_RD;
					end else begin
						t_raddr = AW'(idx_q + CW'(1));
						state_d = S_SHIFT_WR;
					end
				end else begin
					if (idx_q <= pos_q) begin
						if (fw_en_q) begin
							t_we = 1'b1; t_waddr = fw_addr_q;
							t_wstart = fw_start_q; t_wlen = fw_len_q;
						end
						state_d = S_SUM_RD;
					end else begin
						t_raddr = AW'(idx_q - CW'(1));
						state_d = S_SHIFT_WR;
					end
				end
			end
			S_SHIFT_WR: begin
				t_we = 1'b1; t_waddr = idx_q[AW-1:0];
				t_wstart = t_rstart; t_wlen = t_rlen;
				idx_d = remove_q ? idx_q + CW'(1) : idx_q - CW'(1);
				state_d = S_SHIFT_RD;
			end
			S_SUM_RD: begin
				// first entry of the summing walk
				idx_d = '0; sum_d = '0;
				t_raddr = '0;
				state_d = S_SUM;
			end
			S_SUM: begin
				if (idx_q >= count_q) begin
					state_d = S_DONE;
				end else begin
					sum_d = sum_q + t_rlen;
					idx_d = idx_q + CW'(1);
					t_raddr = idx_d[AW-1:0];
				end
			end
			S_DONE: begin
				// wait here while the previous result beat is still held
				if (req_q.cmd == CMD_TOTAL) ans_d = (sum_q >= req_q.seg_size);
				if (!ovalid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d; req_q <= req_d; found_q <= found_d; pick_q <= pick_d;
		pick_len_q <= pick_len_d; pick_start_q <= pick_start_d; bad_q <= bad_d;
		pos_q <= pos_d; lo_start_q <= lo_start_d; lo_len_q <= lo_len_d;
		hi_start_q <= hi_start_d; hi_len_q <= hi_len_d; ans_q <= ans_d;
		stat_q <= stat_d; abase_q <= abase_d; sum_q <= sum_d;
		remove_q <= remove_d;
		fw_addr_q <= fw_addr_d; fw_start_q <= fw_start_d; fw_len_q <= fw_len_d;
		fw_en_q <= fw_en_d;
		if (load_out) begin
			odata_q.status     <= stat_q;
			odata_q.alloc_base <= abase_q;
			odata_q.answer     <= (req_q.cmd == CMD_TOTAL) ? (sum_q >= req_q.seg_size)
				: ans_q;
			odata_q.free_total <= sum_q;
		end
	end
endmodule

[sv/fhsa_table.sv]
module fhsa_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wstart,
	input  logic [16:0]   wlen,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rstart,
	output logic [16:0]   rlen
);
	logic [32:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wstart, wlen};
		end
		{rstart, rlen} <= mem[raddr];
	end
endmodule

[sv/fhsa_checker.sv]
module fhsa_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input fhsa_pkg::rsp_t rsp_data
);
	import fhsa_pkg::*;
`include "free_hole_segment_allocator_macros.svh"

	`FHSA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`FHSA_ASSERT_NXT(a_rsp_holds, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_data))
	`FHSA_ASSERT_IMP(a_status_code, clk, arst_n, rsp_valid,
		rsp_data.status == ST_OK || rsp_data.status == ST_FAIL
		|| rsp_data.status == ST_FULL)
endmodule

bind free_hole_segment_allocator fhsa_checker u_fhsa_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

[tb/sv/fhsa_tb_if.sv]
`timescale 1ns / 1ps
// Stimulus record: one row of the directed table.
package fhsa_tb_pkg;
	import fhsa_pkg::*;

	typedef struct {
		logic [2:0]  cmd;
		logic [15:0] seg_base;
		logic [16:0] seg_size;
		bit          known;
		rsp_t        rsp;
	} vec_t;
endpackage

[tb/sv/tb_free_hole_segment_allocator.sv]
`timescale 1ns / 1ps
module tb_free_hole_segment_allocator;
	import fhsa_pkg::*;
	import fhsa_tb_pkg::*;

	localparam int MAXH = 16;
	localparam int LIMIT_CYCLES = 1000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_data;

	fhsa_req_if req ();
	fhsa_rsp_if rsp ();

	free_hole_segment_allocator #(.MAX_HOLES(MAXH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.rsp       (rsp.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the allocator: configuration and hole table
	logic [1:0]  pol;
	logic [16:0] mem_sz;
	logic [16:0] rsv_sz;
	logic [15:0] h_base [MAXH];
	logic [16:0] h_len  [MAXH];
	int          h_cnt;

	rsp_t pending_rsp [$];
	int   n_bad;
	int   cyc;
	int   snd_idle;   // percent idle of the sender
	int   rcv_stall;  // percent stall of the receiver

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle watchdog
	initial begin
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc > LIMIT_CYCLES) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		n_bad++;
		$display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
	endtask

	function automatic logic [16:0] free_sum();
		logic [16:0] s;
		s = '0;
		for (int i = 0; i < h_cnt; i++) s += h_len[i];
		return s;
	endfunction

	function automatic void drop_hole(int p);
		for (int i = p; i + 1 < h_cnt; i++) begin
			h_base[i] = h_base[i+1];
			h_len[i]  = h_len[i+1];
		end
		h_cnt--;
	endfunction

	function automatic status_t alloc_hole(logic [16:0] sz, output logic [15:0] b);
		int  pick;
		bit  found;
		pick = 0;
		found = 0;
		b = '0;
		for (int i = 0; i < h_cnt; i++) begin
			if (h_len[i] < sz) continue;
			if (!found) begin
				pick = i;
				found = 1;
				if (pol != POL_BEST && pol != POL_WORST) break;
			end else if (pol == POL_BEST && h_len[i] < h_len[pick]) begin
				pick = i;
			end else if (pol == POL_WORST && h_len[i] > h_len[pick]) begin
				pick = i;
			end
		end
		if (!found) return ST_FAIL;
		b = h_base[pick];
		if (h_len[pick] == sz) drop_hole(pick);
		else begin
			h_base[pick] += sz[15:0];
			h_len[pick]  -= sz;
		end
		return ST_OK;
	endfunction

	function automatic status_t release_region(logic [15:0] b, logic [16:0] sz);
		int unsigned e;
		int p;
		bit lo, hi;
		e = b + sz;
		p = 0;
		if (sz == 0) return ST_OK;
		if (e > ADDR_LIMIT) return ST_FAIL;
		for (int i = 0; i < h_cnt; i++) begin
			if (h_base[i] < e && int'(b) < int'(h_base[i]) + int'(h_len[i])) return ST_FAIL;
			if (h_base[i] < b) p = i + 1;
		end
		lo = p > 0 && int'(h_base[p-1]) + int'(h_len[p-1]) == int'(b);
		hi = p < h_cnt && e == h_base[p];
		if (lo && hi) begin
			h_len[p-1] += sz + h_len[p];
			drop_hole(p);
		end else if (lo) begin
			h_len[p-1] += sz;
		end else if (hi) begin
			h_base[p] = b;
			h_len[p]  += sz;
		end else begin
			if (h_cnt >= MAXH) return ST_FULL;
			for (int i = h_cnt; i > p; i--) begin
				h_base[i] = h_base[i-1];
				h_len[i]  = h_len[i-1];
			end
			h_base[p] = b;
			h_len[p]  = sz;
			h_cnt++;
		end
		return ST_OK;
	endfunction

	function automatic rsp_t predict_rsp(logic [2:0] c, logic [15:0] b, logic [16:0] sz);
		rsp_t r;
		int unsigned top;
		r = '0;
		case (c)
			CMD_ALLOC: r.status = alloc_hole(sz, r.alloc_base);
			CMD_FREE:  r.status = release_region(b, sz);
			CMD_TOTAL: r.answer = free_sum() >= sz;
			CMD_CONTIG: begin
				for (int i = 0; i < h_cnt; i++) if (h_len[i] >= sz) r.answer = 1'b1;
			end
			CMD_INIT: begin
				top = mem_sz > ADDR_LIMIT ? ADDR_LIMIT : mem_sz;
				h_cnt = 0;
				if (rsv_sz < top) begin
					h_base[0] = rsv_sz[15:0];
					h_len[0]  = 17'(top - rsv_sz);
					h_cnt = 1;
				end
			end
			default: ;
		endcase
		r.free_total = free_sum();
		return r;
	endfunction

	// one beat: predict, then wait for acceptance; valid stays up for a following beat
	task automatic send_beat(logic [2:0] c, logic [15:0] b, logic [16:0] sz,
			bit known, rsp_t want);
		rsp_t p;
		if ($urandom_range(99) < snd_idle) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		p = predict_rsp(c, b, sz);
		if (known && p != want)
			report_mismatch("table row vs predictor", int'(p.free_total),
				int'(want.free_total));
		pending_rsp.push_back(p);
		req.valid <= 1'b1;
		req.data  <= '{cmd: c, seg_base: b, seg_size: sz};
		do @(posedge clk); while (!req.ready);
	endtask

	// receiver: random back-pressure, checks each result beat
	always @(posedge clk) begin
		rsp_t w;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (pending_rsp.size() == 0) report_mismatch("unexpected beat", 1, 0);
				else begin
					w = pending_rsp.pop_front();
					if (rsp.data.status != w.status)
						report_mismatch("status", rsp.data.status, w.status);
					if (rsp.data.alloc_base != w.alloc_base)
						report_mismatch("alloc_base", rsp.data.alloc_base, w.alloc_base);
					if (rsp.data.answer != w.answer)
						report_mismatch("answer", rsp.data.answer, w.answer);
					if (rsp.data.free_total != w.free_total)
						report_mismatch("free_total", rsp.data.free_total, w.free_total);
				end
			end
			rsp.ready <= $urandom_range(99) >= rcv_stall;
		end
	end

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4 * MAXH + 20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [16:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POLICY:   pol = v[1:0];
			REG_MEM_SIZE: mem_sz = v;
			REG_RESERVED: rsv_sz = v;
			default: ;
		endcase
	endtask

	// random traffic, mostly allocs and frees of recently taken blocks
	task automatic random_burst(int n);
		logic [15:0] tb_base [$];
		logic [16:0] tb_len  [$];
		logic [2:0]  c;
		logic [15:0] b;
		logic [16:0] sz;
		int k, r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			b = 16'($urandom);
			sz = 17'($urandom_range(1, 600));
			if (r < 40) c = CMD_ALLOC;
			else if (r < 75) begin
				c = CMD_FREE;
				if (tb_base.size() != 0) begin
					k = $urandom_range(tb_base.size() - 1);
					b = tb_base[k];
					sz = tb_len[k];
					// sometimes release only part of a block
					if ($urandom_range(3) == 0 && sz > 1) sz = 17'($urandom_range(1, sz));
					tb_base.delete(k);
					tb_len.delete(k);
				end else if ($urandom_range(1)) sz = 17'($urandom_range(0, 17'h1ffff));
			end else if (r < 85) begin
				c = $urandom_range(1) ? CMD_TOTAL : CMD_CONTIG;
				sz = 17'($urandom_range(0, 17'h1ffff));
				if ($urandom_range(1)) sz = 17'($urandom_range(0, 5000));
			end else if (r < 95) begin
				c = CMD_ALLOC;
				sz = 17'($urandom_range(0, 17'h1ffff));
			end else if (r < 98) c = 3'($urandom_range(5, 7));
			else c = CMD_INIT;
			if (c == CMD_ALLOC && pol == 2'd0 && $urandom_range(1))
				sz = 17'($urandom_range(1, 64));
			if (c == CMD_INIT) begin
				tb_base.delete();
				tb_len.delete();
			end
			if (c == CMD_ALLOC) begin
				rsp_t p;
				// peek the outcome on a copy would double work; track base after send
				send_beat(c, b, sz, 0, p);
				if (pending_rsp[$].status == ST_OK && sz != 0) begin
					tb_base.push_back(pending_rsp[$].alloc_base);
					tb_len.push_back(sz);
				end
			end else send_beat(c, b, sz, 0, '0);
		end
	endtask

	vec_t dir_tab [] = '{
		// after reset: nothing free until init
		'{CMD_TOTAL, 16'd0, 17'd0, 1, '{ST_OK, 16'd0, 1'b1, 17'd0}},
		'{CMD_CONTIG, 16'd0, 17'd0, 1, '{ST_OK, 16'd0, 1'b0, 17'd0}},
		'{CMD_ALLOC, 16'd0, 17'd0, 1, '{ST_FAIL, 16'd0, 1'b0, 17'd0}},
		'{CMD_INIT, 16'd0, 17'd0, 1, '{ST_OK, 16'd0, 1'b0, 17'd3968}},
		'{CMD_ALLOC, 16'd0, 17'd0, 1, '{ST_OK, 16'd128, 1'b0, 17'd3968}},
		'{CMD_ALLOC, 16'd0, 17'd100, 1, '{ST_OK, 16'd128, 1'b0, 17'd3868}},
		'{CMD_ALLOC, 16'd0, 17'h1ffff, 1, '{ST_FAIL, 16'd0, 1'b0, 17'd3868}},
		'{CMD_ALLOC, 16'd0, 17'd200, 0, '0},
		'{CMD_ALLOC, 16'd0, 17'd300, 0, '0},
		'{CMD_FREE, 16'd228, 17'd0, 1, '{ST_OK, 16'd0, 1'b0, 17'd3368}},
		'{CMD_FREE, 16'd228, 17'd200, 0, '0},       // lone hole
		'{CMD_FREE, 16'd128, 17'd100, 0, '0},       // merge upper
		'{CMD_FREE, 16'd300, 17'd50, 1, '{ST_FAIL, 16'd0, 1'b0, 17'd3668}}, // overlap
		'{CMD_FREE, 16'hffff, 17'd2, 1, '{ST_FAIL, 16'd0, 1'b0, 17'd3668}}, // past end
		'{CMD_FREE, 16'hffff, 17'd1, 0, '0},
		'{CMD_FREE, 16'd428, 17'd300, 0, '0},       // merge both
		'{CMD_TOTAL, 16'd0, 17'h1ffff, 0, '0},
		'{CMD_CONTIG, 16'd0, 17'd4096, 0, '0},
		'{CMD_CONTIG, 16'd0, 17'd1, 0, '0},
		'{3'd5, 16'hffff, 17'h1ffff, 0, '0},
		'{3'd7, 16'h0000, 17'h10000, 0, '0},
		'{3'd6, 16'h5555, 17'h0aaaa, 0, '0}
	};

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_POLICY;
		cfg_data  = '0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
		n_bad = 0;
		pol = 2'd0;
		mem_sz = 17'd4096;
		rsv_sz = 17'd128;
		h_cnt = 0;
		snd_idle = 0;
		rcv_stall = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_beat(dir_tab[i].cmd, dir_tab[i].seg_base, dir_tab[i].seg_size,
				dir_tab[i].known, dir_tab[i].rsp);
		drain();

		// table full: 16 separate holes, then one more needing an entry
		write_reg(REG_RESERVED, 17'd0);
		write_reg(REG_MEM_SIZE, 17'd64);
		send_beat(CMD_INIT, 16'd0, 17'd0, 1, '{ST_OK, 16'd0, 1'b0, 17'd64});
		send_beat(CMD_ALLOC, 16'd0, 17'd64, 1, '{ST_OK, 16'd0, 1'b0, 17'd0});
		for (int i = 0; i < MAXH; i++) send_beat(CMD_FREE, 16'(4 * i), 17'd1, 0, '0);
		send_beat(CMD_FREE, 16'd66, 17'd1, 1, '{ST_FULL, 16'd0, 1'b0, 17'd16});
		send_beat(CMD_FREE, 16'd1, 17'd1, 0, '0);
		drain();

		// phases: policy, memory shape and idling vary together
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin snd_idle = 0;  rcv_stall = 0;  end
				1: begin snd_idle = 67; rcv_stall = 0;  end
				2: begin snd_idle = 0;  rcv_stall = 67; end
				default: begin snd_idle = 37; rcv_stall = 37; end
			endcase
			write_reg(REG_POLICY, 17'(ph % 4));
			case (ph)
				0: begin write_reg(REG_MEM_SIZE, 17'h1ffff); write_reg(REG_RESERVED, 17'd0); end
				1: begin write_reg(REG_MEM_SIZE, 17'd65536); write_reg(REG_RESERVED, 17'd65535); end
				2: begin write_reg(REG_MEM_SIZE, 17'd1); write_reg(REG_RESERVED, 17'h1ffff); end
				default: begin
					write_reg(REG_MEM_SIZE, 17'($urandom_range(1000, 65536)));
					write_reg(REG_RESERVED, 17'($urandom_range(0, 900)));
				end
			endcase
			send_beat(CMD_INIT, '0, '0, 0, '0);
			random_burst(ph == 2 ? 40 : 100);
			drain();
		end

		if (n_bad == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/fhsa_pkg.sv
sv/fhsa_if.sv
sv/fhsa_table.sv
sv/free_hole_segment_allocator.sv
sv/fhsa_checker.sv
tb/sv/fhsa_tb_if.sv
tb/sv/tb_free_hole_segment_allocator.sv
